### hdl/adi_pkg.sv
// shared constants and types for the affine 2d matrix inverse unit
package adi_pkg;

  localparam int ADI_W         = 32;
  localparam int ADI_DW        = 64;
  localparam int ADI_QBITS     = 34;
  localparam int ADI_NW        = ADI_DW + 32;
  localparam int ADI_SH_LIN    = 32;
  localparam int ADI_SH_TR     = 16;
  localparam int ADI_FRONT_LAT = 3;
  localparam int ADI_DIV_LAT   = ADI_QBITS + 4;
  localparam int ADI_LAT       = ADI_FRONT_LAT + ADI_DIV_LAT;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SNG = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic              sat;
    logic [ADI_W-1:0]  q;
  } adi_res_t;

endpackage

### hdl/adi_front.sv
// products, determinant and adjoint numerators
module adi_front import adi_pkg::*; (
  input  logic                     clk,
  input  logic signed [ADI_W-1:0]  m_xx,
  input  logic signed [ADI_W-1:0]  m_yx,
  input  logic signed [ADI_W-1:0]  m_xy,
  input  logic signed [ADI_W-1:0]  m_yy,
  input  logic signed [ADI_W-1:0]  m_tx,
  input  logic signed [ADI_W-1:0]  m_ty,
  output logic signed [ADI_DW-1:0] det,
  output logic signed [ADI_DW-1:0] a_xx,
  output logic signed [ADI_DW-1:0] a_yx,
  output logic signed [ADI_DW-1:0] a_xy,
  output logic signed [ADI_DW-1:0] a_yy,
  output logic signed [ADI_DW-1:0] a_tx,
  output logic signed [ADI_DW-1:0] a_ty
);

  logic signed [ADI_W-1:0]  xx_r, yx_r, xy_r, yy_r, tx_r, ty_r;
  logic signed [ADI_DW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [ADI_DW-1:0] b_xx_r, b_yx_r, b_xy_r, b_yy_r;
  logic signed [ADI_DW-1:0] det_r, a_xx_r, a_yx_r, a_xy_r, a_yy_r, a_tx_r, a_ty_r;

  always_ff @(posedge clk) begin
    xx_r <= m_xx;
    yx_r <= m_yx;
    xy_r <= m_xy;
    yy_r <= m_yy;
    tx_r <= m_tx;
    ty_r <= m_ty;
  end

  always_ff @(posedge clk) begin
    p0_r   <= ADI_DW'(xx_r) * ADI_DW'(yy_r);
    p1_r   <= ADI_DW'(yx_r) * ADI_DW'(xy_r);
    p2_r   <= ADI_DW'(xy_r) * ADI_DW'(ty_r);
    p3_r   <= ADI_DW'(yy_r) * ADI_DW'(tx_r);
    p4_r   <= ADI_DW'(yx_r) * ADI_DW'(tx_r);
    p5_r   <= ADI_DW'(xx_r) * ADI_DW'(ty_r);
    b_xx_r <= ADI_DW'(yy_r);
    b_yx_r <= -ADI_DW'(yx_r);
    b_xy_r <= -ADI_DW'(xy_r);
    b_yy_r <= ADI_DW'(xx_r);
  end

  always_ff @(posedge clk) begin
    det_r  <= p0_r - p1_r;
    a_tx_r <= p2_r - p3_r;
    a_ty_r <= p4_r - p5_r;
    a_xx_r <= b_xx_r;
    a_yx_r <= b_yx_r;
    a_xy_r <= b_xy_r;
    a_yy_r <= b_yy_r;
  end

  assign det  = det_r;
  assign a_xx = a_xx_r;
  assign a_yx = a_yx_r;
  assign a_xy = a_xy_r;
  assign a_yy = a_yy_r;
  assign a_tx = a_tx_r;
  assign a_ty = a_ty_r;

endmodule

### hdl/adi_div.sv
// pipelined rounded fixed-point divider, one quotient bit per stage
module adi_div import adi_pkg::*; #(
  parameter int SHIFT = ADI_SH_LIN
) (
  input  logic                     clk,
  input  logic signed [ADI_DW-1:0] num,
  input  logic signed [ADI_DW-1:0] den,
  output adi_res_t                 res
);

  localparam int QB = ADI_QBITS;

  logic [ADI_DW-1:0] mag1_r, d1_r;
  logic              neg1_r;
  logic [ADI_NW-1:0] nfull;

  logic [ADI_DW-1:0] r_r   [0:QB];
  logic [QB-1:0]     q_r   [0:QB];
  logic [QB-1:0]     nlo_r [0:QB];
  logic [ADI_DW-1:0] d_r   [0:QB];
  logic              neg_r [0:QB];
  logic              ovf_r [0:QB];

  logic [QB:0]       qr_r;
  logic              negf_r, ovff_r, rnd;
  adi_res_t          res_r;

  always_ff @(posedge clk) begin
    mag1_r <= num[ADI_DW-1] ? ADI_DW'(-num) : ADI_DW'(num);
    d1_r   <= den[ADI_DW-1] ? ADI_DW'(-den) : ADI_DW'(den);
    neg1_r <= num[ADI_DW-1] ^ den[ADI_DW-1];
  end

  assign nfull = ADI_NW'(mag1_r) << SHIFT;

  always_ff @(posedge clk) begin
    r_r[0]   <= ADI_DW'(nfull[ADI_NW-1:QB]);
    q_r[0]   <= '0;
    nlo_r[0] <= nfull[QB-1:0];
    d_r[0]   <= d1_r;
    neg_r[0] <= neg1_r;
    ovf_r[0] <= ADI_DW'(nfull[ADI_NW-1:QB]) >= d1_r;
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [ADI_DW:0] t;
    logic            ge;
    always_comb begin
      t  = {r_r[j], nlo_r[j][QB-1-j]};
      ge = t >= {1'b0, d_r[j]};
    end
    always_ff @(posedge clk) begin
      r_r[j+1]   <= ge ? ADI_DW'(t - {1'b0, d_r[j]}) : t[ADI_DW-1:0];
      q_r[j+1]   <= {q_r[j][QB-2:0], ge};
      nlo_r[j+1] <= nlo_r[j];
      d_r[j+1]   <= d_r[j];
      neg_r[j+1] <= neg_r[j];
      ovf_r[j+1] <= ovf_r[j];
    end
  end

  assign rnd = {r_r[QB], 1'b0} >= {1'b0, d_r[QB]};

  always_ff @(posedge clk) begin
    qr_r   <= {1'b0, q_r[QB]} + (QB+1)'(rnd);
    negf_r <= neg_r[QB];
    ovff_r <= ovf_r[QB];
  end

  always_ff @(posedge clk) begin
    if (!negf_r) begin
      res_r.sat <= ovff_r || (qr_r > (QB+1)'(32'h7FFF_FFFF));
      res_r.q   <= (ovff_r || (qr_r > (QB+1)'(32'h7FFF_FFFF))) ? 32'h7FFF_FFFF : qr_r[ADI_W-1:0];
    end else begin
      res_r.sat <= ovff_r || (qr_r > (QB+1)'(32'h8000_0000));
      res_r.q   <= (ovff_r || (qr_r > (QB+1)'(32'h8000_0000))) ? 32'h8000_0000
                                                                : -qr_r[ADI_W-1:0];
    end
  end

  assign res = res_r;

endmodule

### hdl/affine_2d_matrix_invert_unit.sv
// top level of the affine 2d matrix inverse unit
//   channel  | ports                                 | handshake
//   input    | in_m_xx .. in_m_ty                    | start, busy (busy always low)
//   result   | out_inv_xx .. out_inv_ty, out_status  | out_valid strobe, one cycle
// one matrix per cycle, since busy stays low.
// pipeline: 3 front stages plus 38 divider stages (34 quotient bits, 4 around them), then the output registers.
// synchronous reset clears the valid pipeline; data registers are not reset.
// no stall path: the receiver takes every beat.
module affine_2d_matrix_invert_unit import adi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ADI_W-1:0] in_m_xx,
  input  logic signed [ADI_W-1:0] in_m_yx,
  input  logic signed [ADI_W-1:0] in_m_xy,
  input  logic signed [ADI_W-1:0] in_m_yy,
  input  logic signed [ADI_W-1:0] in_m_tx,
  input  logic signed [ADI_W-1:0] in_m_ty,
  output logic                    out_valid,
  output logic signed [ADI_W-1:0] out_inv_xx,
  output logic signed [ADI_W-1:0] out_inv_yx,
  output logic signed [ADI_W-1:0] out_inv_xy,
  output logic signed [ADI_W-1:0] out_inv_yy,
  output logic signed [ADI_W-1:0] out_inv_tx,
  output logic signed [ADI_W-1:0] out_inv_ty,
  output logic [1:0]              out_status
);

  logic signed [ADI_DW-1:0] det, a_xx, a_yx, a_xy, a_yy, a_tx, a_ty;
  adi_res_t                 r_xx, r_yx, r_xy, r_yy, r_tx, r_ty;
  logic [ADI_LAT-1:0]       vld_r, vld_nxt;
  logic [ADI_DIV_LAT-1:0]   zero_r;
  logic                     any_sat;

  logic                    out_valid_r;
  logic signed [ADI_W-1:0] xx_r, yx_r, xy_r, yy_r, tx_r, ty_r;
  logic [1:0]              status_r;

  assign busy = 1'b0;

  adi_front u_front (
    .clk  (clk),
    .m_xx (in_m_xx), .m_yx (in_m_yx), .m_xy (in_m_xy),
    .m_yy (in_m_yy), .m_tx (in_m_tx), .m_ty (in_m_ty),
    .det  (det),
    .a_xx (a_xx), .a_yx (a_yx), .a_xy (a_xy),
    .a_yy (a_yy), .a_tx (a_tx), .a_ty (a_ty)
  );

  adi_div #(.SHIFT(ADI_SH_LIN)) u_div_xx (.clk(clk), .num(a_xx), .den(det), .res(r_xx));
  adi_div #(.SHIFT(ADI_SH_LIN)) u_div_yx (.clk(clk), .num(a_yx), .den(det), .res(r_yx));
  adi_div #(.SHIFT(ADI_SH_LIN)) u_div_xy (.clk(clk), .num(a_xy), .den(det), .res(r_xy));
  adi_div #(.SHIFT(ADI_SH_LIN)) u_div_yy (.clk(clk), .num(a_yy), .den(det), .res(r_yy));
  adi_div #(.SHIFT(ADI_SH_TR))  u_div_tx (.clk(clk), .num(a_tx), .den(det), .res(r_tx));
  adi_div #(.SHIFT(ADI_SH_TR))  u_div_ty (.clk(clk), .num(a_ty), .den(det), .res(r_ty));

  assign vld_nxt = {vld_r[ADI_LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[ADI_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= {zero_r[ADI_DIV_LAT-2:0], det == '0};
  end

  assign any_sat = r_xx.sat | r_yx.sat | r_xy.sat | r_yy.sat | r_tx.sat | r_ty.sat;

  always_ff @(posedge clk) begin
    if (zero_r[ADI_DIV_LAT-1]) begin
      xx_r     <= '0;
      yx_r     <= '0;
      xy_r     <= '0;
      yy_r     <= '0;
      tx_r     <= '0;
      ty_r     <= '0;
      status_r <= ST_SNG;
    end else begin
      xx_r     <= r_xx.q;
      yx_r     <= r_yx.q;
      xy_r     <= r_xy.q;
      yy_r     <= r_yy.q;
      tx_r     <= r_tx.q;
      ty_r     <= r_ty.q;
      status_r <= any_sat ? ST_SAT : ST_OK;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_inv_xx = xx_r;
  assign out_inv_yx = yx_r;
  assign out_inv_xy = xy_r;
  assign out_inv_yy = yy_r;
  assign out_inv_tx = tx_r;
  assign out_inv_ty = ty_r;
  assign out_status = status_r;

endmodule

### hdl/adi_checker.sv
// port-level checks for the affine 2d matrix inverse unit
module adi_checker import adi_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic signed [ADI_W-1:0] out_inv_xx,
  input logic signed [ADI_W-1:0] out_inv_yx,
  input logic signed [ADI_W-1:0] out_inv_xy,
  input logic signed [ADI_W-1:0] out_inv_yy,
  input logic signed [ADI_W-1:0] out_inv_tx,
  input logic signed [ADI_W-1:0] out_inv_ty,
  input logic [1:0]              out_status
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(ADI_LAT+1) out_valid)
    else $error("accepted beat produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, ADI_LAT+1))
    else $error("result without an accepted beat");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_SNG || out_status == ST_SAT))
    else $error("undefined status code");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SNG |->
      out_inv_xx == '0 && out_inv_yx == '0 && out_inv_xy == '0 &&
      out_inv_yy == '0 && out_inv_tx == '0 && out_inv_ty == '0)
    else $error("singular result not zero");

endmodule

bind affine_2d_matrix_invert_unit adi_checker u_adi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_inv_xx (out_inv_xx),
  .out_inv_yx (out_inv_yx),
  .out_inv_xy (out_inv_xy),
  .out_inv_yy (out_inv_yy),
  .out_inv_tx (out_inv_tx),
  .out_inv_ty (out_inv_ty),
  .out_status (out_status)
);

### sim/tb_affine_2d_matrix_invert_unit.sv
// self-checking testbench for the affine 2d matrix inverse unit
module tb_affine_2d_matrix_invert_unit;
  import adi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 4000;
  localparam logic signed [31:0] Q1 = 32'sh0001_0000;

  typedef struct packed {
    logic [31:0] xx, yx, xy, yy, tx, ty;
    logic [1:0]  status;
  } inv_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_m_xx = '0, in_m_yx = '0, in_m_xy = '0;
  logic signed [31:0] in_m_yy = '0, in_m_tx = '0, in_m_ty = '0;
  logic out_valid;
  logic signed [31:0] out_inv_xx, out_inv_yx, out_inv_xy, out_inv_yy, out_inv_tx, out_inv_ty;
  logic [1:0] out_status;

  inv_t inverse_q[$];
  int   errors = 0;
  int   quiet_cycles = 0;
  bit   gaps_on = 1'b1;

  affine_2d_matrix_invert_unit u_top (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] round_div(input logic signed [65:0] num, input int sh,
                                            input logic signed [65:0] den, inout bit sat);
    logic [127:0] mag, dmag, q, r;
    bit neg;
    neg  = (num < 0) != (den < 0);
    mag  = (num < 0) ? 128'(-num) : 128'(num);
    dmag = (den < 0) ? 128'(-den) : 128'(den);
    mag  = mag << sh;
    q = mag / dmag;
    r = mag % dmag;
    if (2 * r >= dmag) q = q + 1;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        q = 128'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 128'h8000_0000) begin
      sat = 1'b1;
      q = 128'h8000_0000;
    end
    return 32'(-q[31:0]);
  endfunction

  function automatic inv_t invert_matrix(input logic signed [31:0] xx, yx, xy, yy, tx, ty);
    logic signed [65:0] det;
    inv_t r;
    bit sat;
    sat = 1'b0;
    r = '0;
    det = 66'(xx) * 66'(yy) - 66'(yx) * 66'(xy);
    if (det == 0) begin
      r.status = ST_SNG;
      return r;
    end
    r.xx = round_div(66'(yy), 32, det, sat);
    r.yx = round_div(-66'(yx), 32, det, sat);
    r.xy = round_div(-66'(xy), 32, det, sat);
    r.yy = round_div(66'(xx), 32, det, sat);
    r.tx = round_div(66'(xy) * 66'(ty) - 66'(yy) * 66'(tx), 16, det, sat);
    r.ty = round_div(66'(yx) * 66'(tx) - 66'(xx) * 66'(ty), 16, det, sat);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // capture accepted beats and check results
  always @(posedge clk) begin
    inv_t w;
    bit   hit;
    if (rst_n) begin
      hit = (start && !busy) || out_valid;
      quiet_cycles <= hit ? 0 : quiet_cycles + 1;
      if (start && !busy) begin
        inverse_q.push_back(invert_matrix(in_m_xx, in_m_yx, in_m_xy, in_m_yy, in_m_tx, in_m_ty));
      end
      if (out_valid) begin
        if (inverse_q.size() == 0) begin
          report("unexpected beat", 32'(out_status), 32'h0);
        end else begin
          w = inverse_q.pop_front();
          if (out_inv_xx !== w.xx) report("inv_xx", out_inv_xx, w.xx);
          if (out_inv_yx !== w.yx) report("inv_yx", out_inv_yx, w.yx);
          if (out_inv_xy !== w.xy) report("inv_xy", out_inv_xy, w.xy);
          if (out_inv_yy !== w.yy) report("inv_yy", out_inv_yy, w.yy);
          if (out_inv_tx !== w.tx) report("inv_tx", out_inv_tx, w.tx);
          if (out_inv_ty !== w.ty) report("inv_ty", out_inv_ty, w.ty);
          if (out_status !== w.status) report("status", 32'(out_status), 32'(w.status));
        end
      end
      if (quiet_cycles > WATCH_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_matrix(input logic [31:0] xx, yx, xy, yy, tx, ty);
    while (gaps_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_m_xx <= xx;
    in_m_yx <= yx;
    in_m_xy <= xy;
    in_m_yy <= yy;
    in_m_tx <= tx;
    in_m_ty <= ty;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic test_directed();
    send_matrix(Q1, 0, 0, Q1, 0, 0);
    send_matrix(Q1, 0, 0, Q1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_matrix(Q1, 0, 0, Q1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_matrix(32'h2_0000, 0, 0, 32'h0000_8000, 32'h3_0000, 32'hFFFD_0000);
    send_matrix(0, 0, 0, Q1, 5, 7);
    send_matrix(Q1, 0, 0, 0, 5, 7);
    send_matrix(0, 0, 0, 0, 0, 0);
    send_matrix(Q1, Q1, Q1, Q1, 1, 2);
    send_matrix(1, 0, 0, 1, 1, 1);
    send_matrix(32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_matrix(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(0, Q1, Q1, 0, 32'h1234_5678, 32'h8765_4321);
    send_matrix(0, 32'hFFFF_0000, Q1, 0, 3, 32'hFFFF_FFFD);
    send_matrix(3, 0, 0, 3, 1, 32'hFFFF_FFFF);
    send_matrix(Q1, 32'h0000_8000, 32'h0002_0000, Q1, 0, 0);
    send_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_matrix(2, 1, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
  endtask

  function automatic logic [31:0] near_unit();
    return 32'($signed(Q1) + $signed($urandom_range(262143)) - 131072);
  endfunction

  task automatic test_random(input int n);
    logic [31:0] xx, yx, xy, yy;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) gaps_on = 1'b0;
      if (i == n / 2 + 300) gaps_on = 1'b1;
      case ($urandom_range(4))
        0: send_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: begin
          xx = $urandom_range(3) == 0 ? Q1 : near_unit();
          yy = $urandom_range(3) == 0 ? Q1 : near_unit();
          send_matrix(xx, 0, 0, yy, $urandom, $urandom);
        end
        2: send_matrix(near_unit(), 32'($signed($urandom_range(65535)) - 32768),
                       32'($signed($urandom_range(65535)) - 32768), near_unit(),
                       $urandom, $urandom);
        3: begin
          xx = $urandom;
          yx = $urandom;
          send_matrix(xx, yx, xx, yx, $urandom, $urandom);
        end
        default: begin
          xx = $urandom >> $urandom_range(31);
          yy = $urandom >> $urandom_range(31);
          xy = $urandom >> $urandom_range(31);
          yx = $urandom >> $urandom_range(31);
          send_matrix(xx, yx, xy, yy, $urandom, $urandom);
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1930);
    start <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (ADI_LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### sim.f
hdl/adi_pkg.sv
hdl/adi_front.sv
hdl/adi_div.sv
hdl/affine_2d_matrix_invert_unit.sv
hdl/adi_checker.sv
sim/tb_affine_2d_matrix_invert_unit.sv
